### rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants
// character codes, state encodings and the flag group passed between the
// conversion and output stages
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  typedef enum logic [1:0] {
    DAB_IDLE,
    DAB_RUN,
    DAB_FULL
  } dab_state_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SIGN,
    EM_SKIP,
    EM_DIGIT,
    EM_TERM
  } emit_state_e;

  typedef struct packed {
    logic neg;
    logic last;
  } item_flags_t;

endpackage

`default_nettype wire

### rtl/sdc_dabble.sv
// ----------------------------------------------------------------------------
// sdc_dabble: bit-serial binary to bcd converter
// shift-and-add-3, one magnitude bit per cycle, result held until taken
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int NUM_DIGITS = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [VALUE_BITS-1:0]    mag_i,
  input  wire sdc_pkg::item_flags_t     flags_i,
  input  wire logic                     take_i,
  output logic                          idle_o,
  output logic                          full_o,
  output logic [4*NUM_DIGITS-1:0]       bcd_o,
  output sdc_pkg::item_flags_t          flags_o
);
  import sdc_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int BW = 4 * NUM_DIGITS;

  dab_state_e             state_q, state_d;
  logic [VALUE_BITS-1:0]  sr_q, sr_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  item_flags_t            flags_q, flags_d;
  logic [BW-1:0]          adj;
  logic                   load, step;

  // add 3 to every digit of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DAB_IDLE: if (start_i) state_d = DAB_RUN;
      DAB_RUN:  if (cnt_q == CW'(1)) state_d = DAB_FULL;
      DAB_FULL: if (take_i) state_d = DAB_IDLE;
      default:  state_d = DAB_IDLE;
    endcase
  end

  always_comb begin
    load   = (state_q == DAB_IDLE) && start_i;
    step   = (state_q == DAB_RUN);
    idle_o = (state_q == DAB_IDLE);
    full_o = (state_q == DAB_FULL);
  end

  always_comb begin
    sr_d    = sr_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    flags_d = flags_q;
    if (load) begin
      sr_d    = mag_i;
      bcd_d   = '0;
      cnt_d   = CW'(VALUE_BITS);
      flags_d = flags_i;
    end else if (step) begin
      sr_d  = {sr_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {adj[BW-2:0], sr_q[VALUE_BITS-1]};
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DAB_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    flags_q <= flags_d;
  end

  assign bcd_o   = bcd_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

### rtl/sdc_emit.sv
// ----------------------------------------------------------------------------
// sdc_emit: character sequencer
// sign, digits without leading zeros and separator, one per cycle unless
// stalled, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_emit #(
  parameter int NUM_DIGITS = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic [4*NUM_DIGITS-1:0]  bcd_i,
  input  wire sdc_pkg::item_flags_t     flags_i,
  output logic                          idle_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [7:0]                    ascii_char_o,
  output logic                          item_done_o
);
  import sdc_pkg::*;

  localparam int CW = $clog2(NUM_DIGITS + 1);
  localparam int BW = 4 * NUM_DIGITS;

  emit_state_e  state_q, state_d;
  logic [BW-1:0] dig_q, dig_d;
  logic [CW-1:0] cnt_q, cnt_d;
  item_flags_t   flags_q, flags_d;
  logic          valid_q, valid_d;
  logic [7:0]    char_q, char_d;
  logic          done_q, done_d;

  logic          ospace, oload, shift, lead_zero;
  logic [3:0]    top;
  logic [7:0]    ochar;
  logic          odone;

  assign top       = dig_q[BW-1 -: 4];
  assign ospace    = !valid_q || out_ready_i;
  assign lead_zero = (top == 4'd0) && (cnt_q > CW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EM_IDLE:  if (load_i) state_d = flags_i.neg ? EM_SIGN : EM_SKIP;
      EM_SIGN:  if (ospace) state_d = EM_SKIP;
      EM_SKIP:  if (!lead_zero) state_d = EM_DIGIT;
      EM_DIGIT: if (ospace && cnt_q == CW'(1)) state_d = EM_TERM;
      EM_TERM:  if (ospace) state_d = EM_IDLE;
      default:  state_d = EM_IDLE;
    endcase
  end

  always_comb begin
    oload = 1'b0;
    shift = 1'b0;
    ochar = CHAR_ZERO;
    odone = 1'b0;
    unique case (state_q)
      EM_IDLE: ;
      EM_SIGN: begin
        oload = ospace;
        ochar = CHAR_MINUS;
      end
      EM_SKIP: shift = lead_zero;
      EM_DIGIT: begin
        oload = ospace;
        shift = ospace;
        ochar = CHAR_ZERO + {4'h0, top};
      end
      EM_TERM: begin
        oload = ospace;
        ochar = flags_q.last ? CHAR_NL : CHAR_COMMA;
        odone = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    flags_d = flags_q;
    if (state_q == EM_IDLE && load_i) begin
      dig_d   = bcd_i;
      cnt_d   = CW'(NUM_DIGITS);
      flags_d = flags_i;
    end else if (shift) begin
      dig_d = {dig_q[BW-5:0], 4'h0};
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    done_d  = done_q;
    if (oload) begin
      valid_d = 1'b1;
      char_d  = ochar;
      done_d  = odone;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    flags_q <= flags_d;
    char_q  <= char_d;
    done_q  <= done_d;
  end

  assign idle_o       = (state_q == EM_IDLE);
  assign out_valid_o  = valid_q;
  assign ascii_char_o = char_q;
  assign item_done_o  = done_q;

endmodule

`default_nettype wire

### rtl/signed_int_to_decimal_csv.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_csv: signed integer to decimal ascii field
// prints one signed value per request as '-' if negative, decimal digits and
// ',' or newline, one character per output request
// ----------------------------------------------------------------------------
//
//   channel | signals                              | moves
//   --------+--------------------------------------+---------------------------
//   in      | in_valid_i / in_ready_o              | sample_value_i, record_end_i
//   out     | out_valid_o / out_ready_i            | ascii_char_o, item_done_o
//
// a request is converted bit-serially in the bcd converter, and its digits
// wait there until the character sequencer takes them; requests are taken
// only while the converter is idle, so one request is converted at a time
// the output side gives one character per cycle unless stalled, after skipping
// leading zeros at one digit per cycle, and runs while the next request converts
// reset clears both sequencers and the output valid; no memory to clear
// a stalled output holds its character; conversion of the next request
// still completes and waits in the converter
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_csv #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic               record_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              ascii_char_o,
  output logic                    item_done_o
);
  import sdc_pkg::*;

  // decimal digits needed for 2^(VALUE_BITS-1), rounded up safely
  localparam int NUM_DIGITS = (VALUE_BITS * 3) / 10 + 1;

  logic [VALUE_BITS-1:0] raw, mag;
  item_flags_t           in_flags, held_flags;
  logic                  dab_idle, dab_full, emit_idle, handoff, start;
  logic [4*NUM_DIGITS-1:0] bcd;

  // only the low bits count, read as two's complement of that width;
  // the most negative value wraps back to itself, which is its magnitude
  assign raw           = sample_value_i[VALUE_BITS-1:0];
  assign in_flags.neg  = raw[VALUE_BITS-1];
  assign in_flags.last = record_end_i;
  assign mag           = in_flags.neg ? (~raw + VALUE_BITS'(1)) : raw;

  assign in_ready_o = dab_idle;
  assign start      = in_valid_i && dab_idle;

  // hand the digits over as soon as the character sequencer is free
  assign handoff = dab_full && emit_idle;

  sdc_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mag_i   (mag),
    .flags_i (in_flags),
    .take_i  (handoff),
    .idle_o  (dab_idle),
    .full_o  (dab_full),
    .bcd_o   (bcd),
    .flags_o (held_flags)
  );

  sdc_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (handoff),
    .bcd_i        (bcd),
    .flags_i      (held_flags),
    .idle_o       (emit_idle),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .item_done_o  (item_done_o)
  );

endmodule

`default_nettype wire

### rtl/sdc_check.sv
// ----------------------------------------------------------------------------
// sdc_check: port checker
// watches the ports of the top level for framing and hold rules
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  ascii_char_o,
  input wire logic        item_done_o
);
  import sdc_pkg::*;

  // a stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ascii_char_o)
                                     && $stable(item_done_o))
    else $error("stalled output changed");

  // conversion is serial: in_ready stays low after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during conversion");

  // the separator and only the separator ends a field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> item_done_o == (ascii_char_o == CHAR_COMMA
                                    || ascii_char_o == CHAR_NL))
    else $error("field end mark wrong");

  // a minus sign is followed by a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && ascii_char_o == CHAR_MINUS
      |=> !out_valid_o || (ascii_char_o >= CHAR_ZERO
                           && ascii_char_o <= CHAR_ZERO + 8'd9))
    else $error("minus not followed by digit");

endmodule

bind signed_int_to_decimal_csv sdc_check u_check (.*);

`default_nettype wire
